/* hw/rtl/brpg_pkg.sv */
// shared types and constants of the base relocation patch generator
// no dependencies; imported by every module of the block

package brpg_pkg;

    localparam int unsigned FIFO_DEPTH = 4;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned DELTA_W     = 64;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned HALF_W      = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DELTA = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE = 2'd2;

    localparam logic [3:0]  DIR64_TYPE   = 4'hA;
    localparam logic [31:0] HEADER_BYTES = 32'd8;

    typedef enum logic [1:0] {
        OUT_PATCH     = 2'd0,
        OUT_FINISHED  = 2'd1,
        OUT_MALFORMED = 2'd2
    } t_outcome;

    typedef struct packed {
        t_outcome          outcome;
        logic [ADDR_W-1:0] offset;
    } t_result;

endpackage

/* hw/rtl/brpg_front.sv */
// table walker: parses halfwords into headers and entries, classifies each
// word into a result record; depends on brpg_pkg

module brpg_front
    import brpg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [HALF_W-1:0]   i_half_word,
    input  logic                i_first_word,
    input  logic                i_last_word,
    input  logic                i_delta_nz,
    input  logic [ADDR_W-1:0]   i_image_bytes,
    input  logic [ADDR_W-1:0]   i_table_bytes,
    output logic                o_res_valid,
    output t_result             o_res
);

    logic [1:0]        r_hidx,     n_hidx;
    logic [ADDR_W-1:0] r_page,     n_page;
    logic [ADDR_W-1:0] r_size,     n_size;
    logic [ADDR_W-2:0] r_left,     n_left;
    logic [ADDR_W-1:0] r_consumed, n_consumed;
    logic              r_stopped,  n_stopped;

    // state as seen by this word, after an optional clear
    logic [1:0]        e_hidx;
    logic [ADDR_W-1:0] e_page;
    logic [ADDR_W-1:0] e_size;
    logic [ADDR_W-2:0] e_left;
    logic [ADDR_W-1:0] e_consumed;
    logic              e_stopped;

    logic [ADDR_W:0]   patch_off;
    logic              patch_hit;
    logic              hdr_room;
    logic [ADDR_W-1:0] full_size;
    logic [ADDR_W-1:0] size_less_hdr;
    logic              size_bad;

    always_comb begin
        e_hidx     = i_first_word ? '0   : r_hidx;
        e_page     = i_first_word ? '0   : r_page;
        e_size     = i_first_word ? '0   : r_size;
        e_left     = i_first_word ? '0   : r_left;
        e_consumed = i_first_word ? '0   : r_consumed;
        e_stopped  = i_first_word ? 1'b0 : r_stopped;
    end

    // patch bound is checked without wrap, hence the extra bit
    assign patch_off = {1'b0, e_page} + {{(ADDR_W+1-12){1'b0}}, i_half_word[11:0]};
    assign patch_hit = (i_half_word[15:12] == DIR64_TYPE) &&
                       ((patch_off + (ADDR_W+1)'(HEADER_BYTES)) <= {1'b0, i_image_bytes});
    assign hdr_room  = ({1'b0, e_consumed} + {1'b0, HEADER_BYTES}) <= {1'b0, i_table_bytes};
    assign full_size = {i_half_word, e_size[HALF_W-1:0]};
    assign size_less_hdr = full_size - HEADER_BYTES;
    assign size_bad  = (full_size < HEADER_BYTES) || full_size[0] ||
                       (({1'b0, e_consumed} + {1'b0, full_size}) > {1'b0, i_table_bytes});

    always_comb begin
        n_hidx      = e_hidx;
        n_page      = e_page;
        n_size      = e_size;
        n_left      = e_left;
        n_consumed  = e_consumed;
        n_stopped   = e_stopped;
        o_res_valid = 1'b0;
        o_res       = '{outcome: OUT_FINISHED, offset: '0};
        if (i_delta_nz && !e_stopped) begin
            if (e_left != '0) begin
                n_left = e_left - 1'b1;
                if (e_left == (ADDR_W-1)'(1)) begin
                    n_consumed = e_consumed + e_size;
                    n_hidx     = '0;
                end
                if (patch_hit) begin
                    o_res_valid = 1'b1;
                    o_res       = '{outcome: OUT_PATCH, offset: patch_off[ADDR_W-1:0]};
                end
            end else if ((e_hidx != '0) || hdr_room) begin
                unique case (e_hidx)
                    2'd0: n_page = {{(ADDR_W-HALF_W){1'b0}}, i_half_word};
                    2'd1: n_page = {i_half_word, e_page[HALF_W-1:0]};
                    2'd2: n_size = {{(ADDR_W-HALF_W){1'b0}}, i_half_word};
                    default: n_size = full_size;
                endcase
                if (e_hidx != 2'd3) begin
                    n_hidx = e_hidx + 1'b1;
                end else begin
                    n_hidx = '0;
                    if (size_bad) begin
                        n_stopped   = 1'b1;
                        o_res_valid = 1'b1;
                        o_res       = '{outcome: OUT_MALFORMED, offset: '0};
                    end else begin
                        n_left = size_less_hdr[ADDR_W-1:1];
                        // header-only block completes at once
                        if (full_size == HEADER_BYTES) begin
                            n_consumed = e_consumed + full_size;
                        end
                    end
                end
            end
        end
        if (!o_res_valid && i_last_word) begin
            o_res_valid = 1'b1;
            o_res       = '{outcome: OUT_FINISHED, offset: '0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidx     <= '0;
            r_page     <= '0;
            r_size     <= '0;
            r_left     <= '0;
            r_consumed <= '0;
            r_stopped  <= 1'b0;
        end else if (i_accept) begin
            r_hidx     <= n_hidx;
            r_page     <= n_page;
            r_size     <= n_size;
            r_left     <= n_left;
            r_consumed <= n_consumed;
            r_stopped  <= n_stopped;
        end
    end

endmodule

/* hw/rtl/brpg_fifo.sv */
// short result queue between the table walker and the output stage
// depends on brpg_pkg

module brpg_fifo
    import brpg_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    input  logic    i_pop,
    output t_result o_data,
    output logic    o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue count beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_rd_ptr == r_wr_ptr))
        else $error("empty queue with pointers apart");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !do_pop) |=> (r_wr_ptr == $past(r_wr_ptr)))
        else $error("write pointer moved on a full queue");
`endif

endmodule

/* hw/rtl/brpg_back.sv */
// output stage: takes result records from the queue, attaches the add value
// and holds the oldest result until it is popped; depends on brpg_pkg

module brpg_back
    import brpg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_result            i_q_data,
    output logic               o_q_pop,
    input  logic [DELTA_W-1:0] i_delta,
    input  logic               i_pop,
    output logic               o_valid,
    output t_result            o_res,
    output logic [DELTA_W-1:0] o_add_value
);

    logic               r_valid;
    t_result            r_res;
    logic [DELTA_W-1:0] r_add;

    // refill whenever the held result leaves or the stage is empty
    assign o_q_pop = !i_q_empty && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= i_q_data;
            r_add <= (i_q_data.outcome == OUT_PATCH) ? i_delta : '0;
        end
    end

    assign o_valid     = r_valid;
    assign o_res       = r_res;
    assign o_add_value = r_add;

`ifndef SYNTHESIS
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_res.outcome != OUT_PATCH)) |-> ((r_add == '0) && (r_res.offset == '0)))
        else $error("status result carries patch payload");
`endif

endmodule

/* hw/rtl/base_relocation_patch_generator_core.sv */
// Base relocation patch generator, top level: config registers, table walker,
// result queue and output stage; depends on brpg_pkg, brpg_front, brpg_fifo, brpg_back
//
// Feed the relocation table one little-endian halfword per transfer, with first_word
// on the opening word and last_word on the closing one. Each word is classified
// combinationally by the table walker, so a word can be pushed every cycle; the only
// stall comes from the result queue (FIFO_DEPTH entries plus one output register)
// filling up while results are not popped. A word gives at most one result: a patch
// request (offset and the configured delta), a malformed-block stop, or the finished
// status on the last word. Write the config registers only while no transfer is in
// flight; a zero delta turns the walker off so that only finished status comes out.

module base_relocation_patch_generator_core
    import brpg_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH_P = FIFO_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [DELTA_W-1:0]     i_cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic [HALF_W-1:0]      i_half_word,
    input  logic                   i_first_word,
    input  logic                   i_last_word,
    output logic                   empty,
    input  logic                   pop,
    output logic [1:0]             o_outcome,
    output logic [ADDR_W-1:0]      o_patch_offset,
    output logic [DELTA_W-1:0]     o_add_value
);

    logic [DELTA_W-1:0] r_delta;
    logic [ADDR_W-1:0]  r_image;
    logic [ADDR_W-1:0]  r_table;

    logic    accept;
    logic    res_valid;
    t_result res;
    logic    q_empty;
    t_result q_data;
    logic    q_pop;
    logic    out_valid;
    t_result out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta <= '0;
            r_image <= '0;
            r_table <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DELTA: r_delta <= i_cfg_data;
                CFG_IMAGE: r_image <= i_cfg_data[ADDR_W-1:0];
                CFG_TABLE: r_table <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept = push && !full;

    brpg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_half_word   (i_half_word),
        .i_first_word  (i_first_word),
        .i_last_word   (i_last_word),
        .i_delta_nz    (r_delta != '0),
        .i_image_bytes (r_image),
        .i_table_bytes (r_table),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    brpg_fifo #(
        .DEPTH (FIFO_DEPTH_P)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && res_valid),
        .i_data  (res),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    brpg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .i_delta     (r_delta),
        .i_pop       (pop),
        .o_valid     (out_valid),
        .o_res       (out_res),
        .o_add_value (o_add_value)
    );

    assign empty          = !out_valid;
    assign o_outcome      = out_res.outcome;
    assign o_patch_offset = out_res.offset;

endmodule

/* tb/sv/tb_base_relocation_patch_generator_core.sv */
// self-checking testbench of base_relocation_patch_generator_core: directed and random tables
// with a built-in table walk predictor; depends on brpg_pkg and the core's rtl

module tb_base_relocation_patch_generator_core;
    import brpg_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        t_outcome    outcome;
        logic [31:0] offset;
        logic [63:0] value;
    } t_patch_result;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index    = CFG_DELTA;
    logic [DELTA_W-1:0]     i_cfg_data     = '0;
    logic                   push           = 1'b0;
    logic                   full;
    logic [HALF_W-1:0]      i_half_word    = '0;
    logic                   i_first_word   = 1'b0;
    logic                   i_last_word    = 1'b0;
    logic                   empty;
    logic                   pop            = 1'b0;
    logic [1:0]             o_outcome;
    logic [ADDR_W-1:0]      o_patch_offset;
    logic [DELTA_W-1:0]     o_add_value;

    // predictor copy of the registers and walker state
    logic [63:0] delta_reg;
    logic [31:0] image_limit;
    logic [31:0] table_len;
    logic [2:0]  hdr_count;
    logic [31:0] page_base;
    logic [31:0] blk_bytes;
    logic [30:0] entries_due;
    logic [31:0] consumed_bytes;
    logic        walk_halted;

    t_patch_result due_results[$];
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;
    int            words_sent    = 0;
    int            mismatch_count = 0;
    int            cycle_count   = 0;

    base_relocation_patch_generator_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_half_word    (i_half_word),
        .i_first_word   (i_first_word),
        .i_last_word    (i_last_word),
        .empty          (empty),
        .pop            (pop),
        .o_outcome      (o_outcome),
        .o_patch_offset (o_patch_offset),
        .o_add_value    (o_add_value)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [15:0] dir64(input logic [11:0] off);
        return {DIR64_TYPE, off};
    endfunction

    task automatic note_result(input t_outcome oc, input logic [31:0] off,
                               input logic [63:0] val);
        t_patch_result r;
        r.outcome = oc;
        r.offset  = off;
        r.value   = val;
        due_results.push_back(r);
    endtask

    // one table word through the predictor, at most one result
    task automatic walk_word(input logic [15:0] hw, input logic is_first, input logic is_last);
        logic [32:0] target;
        logic        reported;
        reported = 1'b0;
        if (is_first) begin
            hdr_count      = '0;
            page_base      = '0;
            blk_bytes      = '0;
            entries_due    = '0;
            consumed_bytes = '0;
            walk_halted    = 1'b0;
        end
        if (delta_reg != 64'd0 && !walk_halted) begin
            if (entries_due != 0) begin
                target = {1'b0, page_base} + {21'd0, hw[11:0]};
                entries_due = entries_due - 31'd1;
                if (entries_due == 0) begin
                    consumed_bytes = consumed_bytes + blk_bytes;
                    hdr_count = '0;
                end
                // bound check without wrap
                if (hw[15:12] == DIR64_TYPE && target + 33'd8 <= {1'b0, image_limit}) begin
                    note_result(OUT_PATCH, target[31:0], delta_reg);
                    reported = 1'b1;
                end
            end else if (hdr_count != 0 ||
                         {1'b0, consumed_bytes} + 33'd8 <= {1'b0, table_len}) begin
                case (hdr_count)
                    3'd0: page_base = {16'h0, hw};
                    3'd1: page_base = page_base | {hw, 16'h0};
                    3'd2: blk_bytes = {16'h0, hw};
                    default: blk_bytes = blk_bytes | {hw, 16'h0};
                endcase
                if (hdr_count < 3) begin
                    hdr_count = hdr_count + 3'd1;
                end else begin
                    hdr_count = '0;
                    if (blk_bytes < HEADER_BYTES || blk_bytes[0] ||
                        {1'b0, consumed_bytes} + {1'b0, blk_bytes} > {1'b0, table_len}) begin
                        walk_halted = 1'b1;
                        note_result(OUT_MALFORMED, 32'd0, 64'd0);
                        reported = 1'b1;
                    end else begin
                        entries_due = 31'((blk_bytes - HEADER_BYTES) >> 1);
                        if (entries_due == 0) consumed_bytes = consumed_bytes + blk_bytes;
                    end
                end
            end
        end
        if (is_last && !reported) note_result(OUT_FINISHED, 32'd0, 64'd0);
    endtask

    task automatic send_word(input logic [15:0] hw, input logic is_first, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_half_word  <= hw;
        i_first_word <= is_first;
        i_last_word  <= is_last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        walk_word(hw, is_first, is_last);
        words_sent++;
    endtask

    // stop sending, let every due result drain and the walker go quiet
    task automatic settle_block();
        push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // upper data bits of the 32-bit registers carry junk on purpose
    task automatic write_config(input logic [63:0] delta_v, input logic [31:0] image_v,
                                input logic [31:0] table_v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DELTA;
        i_cfg_data  <= delta_v;
        @(posedge i_clk);
        i_cfg_index <= CFG_IMAGE;
        i_cfg_data  <= {32'($urandom), image_v};
        @(posedge i_clk);
        i_cfg_index <= CFG_TABLE;
        i_cfg_data  <= {32'($urandom), table_v};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        delta_reg   = delta_v;
        image_limit = image_v;
        table_len   = table_v;
    endtask

    task automatic test_zero_delta();
        // registers still at reset: walker off, only the finished status comes out
        send_word(16'h1000, 1'b1, 1'b0);
        send_word(16'h000A, 1'b0, 1'b0);
        send_word(dir64(12'h008), 1'b0, 1'b1);
        settle_block();
    endtask

    task automatic test_patch_bounds();
        write_config('1, '1, '1);
        send_word(16'hF000, 1'b1, 1'b0);
        send_word(16'hFFFF, 1'b0, 1'b0);
        send_word(16'h000E, 1'b0, 1'b0);
        send_word(16'h0000, 1'b0, 1'b0);
        // top of the address space: offset plus 8 must not wrap into range
        send_word(dir64(12'hFFF), 1'b0, 1'b0);
        send_word(dir64(12'h000), 1'b0, 1'b0);
        send_word(16'h3123, 1'b0, 1'b0);
        send_word(16'h0000, 1'b0, 1'b1);
        settle_block();
    endtask

    task automatic test_malformed_blocks();
        write_config(64'h8000_0000_0000_0001, '1, 32'd64);
        // size under 8, then stopped until the next first word
        send_word(16'h0000, 1'b1, 1'b0);
        send_word(16'h0000, 1'b0, 1'b0);
        send_word(16'h0007, 1'b0, 1'b0);
        send_word(16'h0000, 1'b0, 1'b0);
        send_word(dir64(12'h010), 1'b0, 1'b1);
        // odd size on the last word: malformed wins over finished
        send_word(16'h0000, 1'b1, 1'b0);
        send_word(16'h0000, 1'b0, 1'b0);
        send_word(16'h0009, 1'b0, 1'b0);
        send_word(16'h0000, 1'b0, 1'b1);
        settle_block();
    endtask

    task automatic test_walk_end();
        write_config(64'd1, '1, 32'd8);
        send_word(16'h0000, 1'b1, 1'b0);
        send_word(16'h0000, 1'b0, 1'b0);
        send_word(16'h0008, 1'b0, 1'b0);
        send_word(16'h0000, 1'b0, 1'b0);
        // no room for another header: word ignored, finished still given
        send_word(dir64(12'h000), 1'b0, 1'b1);
        settle_block();
    endtask

    task automatic send_random_table();
        logic [15:0] tbl_words[$];
        logic [31:0] page;
        logic [31:0] size;
        logic [3:0]  kind;
        logic [11:0] off;
        logic        with_first;
        int          n_blocks;
        int          n_entries;
        if ($urandom_range(0, 99) < 8) begin
            // noise with random markers
            repeat ($urandom_range(1, 8)) begin
                send_word(16'($urandom), $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
            end
            return;
        end
        n_blocks = $urandom_range(1, 4);
        for (int b = 0; b < n_blocks; b++) begin
            n_entries = $urandom_range(0, 10);
            size = 32'(8 + 2 * n_entries);
            if ($urandom_range(0, 99) < 8) begin
                case ($urandom_range(0, 2))
                    0: size = 32'($urandom_range(0, 7));
                    1: size = size + 32'd1;
                    default: size = $urandom;
                endcase
            end
            if ($urandom_range(0, 99) < 20) page = $urandom;
            else page = 32'($urandom_range(0, 31)) << 12;
            tbl_words.push_back(page[15:0]);
            tbl_words.push_back(page[31:16]);
            tbl_words.push_back(size[15:0]);
            tbl_words.push_back(size[31:16]);
            for (int e = 0; e < n_entries; e++) begin
                kind = ($urandom_range(0, 3) != 0) ? DIR64_TYPE : 4'($urandom);
                // offsets near the page end hit the exact image bound
                if ($urandom_range(0, 9) == 0) off = 12'hFF8 + 12'($urandom_range(0, 1));
                else off = 12'($urandom);
                tbl_words.push_back({kind, off});
            end
        end
        with_first = ($urandom_range(0, 9) != 0);
        foreach (tbl_words[i]) begin
            send_word(tbl_words[i], with_first && i == 0, i == tbl_words.size() - 1);
        end
    endtask

    task automatic test_random_tables(input int goal);
        logic [63:0] delta_v;
        logic [31:0] image_v;
        logic [31:0] table_v;
        int          stop_at;
        int          phase_end;
        stop_at = words_sent + goal;
        while (words_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0: begin
                    delta_v = 64'd0;
                    image_v = $urandom;
                    table_v = 32'($urandom_range(16, 255));
                end
                1: begin
                    delta_v = '1;
                    image_v = '1;
                    table_v = '1;
                end
                2: begin
                    delta_v = 64'd1;
                    image_v = 32'd0;
                    table_v = ($urandom_range(0, 1) != 0) ? 32'd0 : 32'd255;
                end
                default: begin
                    delta_v = {$urandom, $urandom};
                    if ($urandom_range(0, 4) != 0) image_v = 32'($urandom_range(1, 32)) << 12;
                    else image_v = $urandom;
                    table_v = 32'($urandom_range(16, 255));
                end
            endcase
            write_config(delta_v, image_v, table_v);
            phase_end = words_sent + $urandom_range(60, 120);
            while (words_sent < phase_end) send_random_table();
            settle_block();
        end
    endtask

    initial begin
        delta_reg      = '0;
        image_limit    = '0;
        table_len      = '0;
        hdr_count      = '0;
        page_base      = '0;
        blk_bytes      = '0;
        entries_due    = '0;
        consumed_bytes = '0;
        walk_halted    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 35;
        recv_idle_pct = 51;
        test_zero_delta();
        test_patch_bounds();
        test_malformed_blocks();
        test_walk_end();
        test_random_tables(410);
        send_idle_pct = 51;
        recv_idle_pct = 35;
        test_random_tables(410);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_tables(410);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // every result transfer is matched against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_patch_result want;
        if (i_rst_n && pop && !empty) begin
            if (due_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: outcome %0d offset %h value %h",
                             o_outcome, o_patch_offset, o_add_value);
            end else begin
                want = due_results.pop_front();
                if (o_outcome !== want.outcome || o_patch_offset !== want.offset ||
                    o_add_value !== want.value) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %0d/%h/%h got %0d/%h/%h",
                                 want.outcome, want.offset, want.value,
                                 o_outcome, o_patch_offset, o_add_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout with %0d results still due", due_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
